// ===== hdl/cpag_pkg.sv =====
// Shared types and constants of the convolution patch address generator.
package cpag_pkg;

    localparam int OFF_W     = 17;
    localparam int POS_W     = 18;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 64;
    localparam int REG_IDX_W = 3;
    localparam int ACT_W     = 3;
    localparam int DIMS      = 4;

    localparam logic [REG_IDX_W-1:0] REG_PATCH_SIZES  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_SIZES = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STRIDES_LOW  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STRIDES_HIGH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAT_HEIGHT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VOL_BASE     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SCATTER_MODE = 3'd6;

    localparam logic [ACT_W-1:0] ACT_COPY = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ZERO = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SKIP = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NONE = 3'd4;

    typedef struct packed {
        logic active;
        logic in_range;
        logic last;
    } elem_flags_t;

endpackage

// ===== hdl/conv_patch_address_generator.sv =====
// Top level of the convolution patch address generator with its register file.
// One input word is accepted every clock cycle unless in_stall is high, and its
// result word passes the position stage, the stride multiply stage and the address
// sum and output register. The scan counters step in the cycle a word is accepted,
// so words follow each other back to back; a stalled output backs up through the
// three registered stages before the input stalls. A word with restart set loads a
// new patch position and matrix row and yields the first element at once.
module conv_patch_address_generator #(
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cpag_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [cpag_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    input  logic signed [cpag_pkg::OFF_W-1:0]   offset_d0,
    input  logic signed [cpag_pkg::OFF_W-1:0]   offset_d1,
    input  logic signed [cpag_pkg::OFF_W-1:0]   offset_d2,
    input  logic signed [cpag_pkg::OFF_W-1:0]   offset_d3,
    input  logic [cpag_pkg::OUT_W-1:0]          row,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cpag_pkg::OUT_W-1:0]          vol_address,
    output logic [cpag_pkg::OUT_W-1:0]          mat_address,
    output logic [cpag_pkg::ACT_W-1:0]          action,
    output logic                                last
);
    import cpag_pkg::*;

    logic [CFG_W-1:0]  patch_sizes_reg;
    logic [CFG_W-1:0]  volume_sizes_reg;
    logic [CFG_W-1:0]  strides_low_reg;
    logic [CFG_W-1:0]  strides_high_reg;
    logic [OUT_W-1:0]  mat_height_reg;
    logic [OUT_W-1:0]  vol_base_reg;
    logic              scatter_mode_reg;

    logic [3:0][DIM_BITS-1:0]   patch_ext;
    logic [3:0][DIM_BITS-1:0]   vol_ext;
    logic [3:0][ADDR_BITS-1:0]  stride;

    logic                       s1_valid;
    logic                       s1_ready;
    logic [3:0][POS_W-1:0]      s1_pos;
    logic [ADDR_BITS-1:0]       s1_mptr;
    elem_flags_t                s1_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_sizes_reg  <= '0;
            volume_sizes_reg <= '0;
            strides_low_reg  <= '0;
            strides_high_reg <= '0;
            mat_height_reg   <= '0;
            vol_base_reg     <= '0;
            scatter_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATCH_SIZES:  patch_sizes_reg  <= cfg_data;
                REG_VOLUME_SIZES: volume_sizes_reg <= cfg_data;
                REG_STRIDES_LOW:  strides_low_reg  <= cfg_data;
                REG_STRIDES_HIGH: strides_high_reg <= cfg_data;
                REG_MAT_HEIGHT:   mat_height_reg   <= cfg_data[OUT_W-1:0];
                REG_VOL_BASE:     vol_base_reg     <= cfg_data[OUT_W-1:0];
                REG_SCATTER_MODE: scatter_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        for (int d = 0; d < DIMS; d++)
        begin
            patch_ext[d] = patch_sizes_reg[16*d +: DIM_BITS];
            vol_ext[d]   = volume_sizes_reg[16*d +: DIM_BITS];
        end
        stride[0] = strides_low_reg[0 +: ADDR_BITS];
        stride[1] = strides_low_reg[32 +: ADDR_BITS];
        stride[2] = strides_high_reg[0 +: ADDR_BITS];
        stride[3] = strides_high_reg[32 +: ADDR_BITS];
    end

    cpag_scan #(
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .offset_d0 (offset_d0),
        .offset_d1 (offset_d1),
        .offset_d2 (offset_d2),
        .offset_d3 (offset_d3),
        .row       (row),
        .patch_ext (patch_ext),
        .vol_ext   (vol_ext),
        .mat_step  (mat_height_reg[ADDR_BITS-1:0]),
        .s1_ready  (s1_ready),
        .s1_valid  (s1_valid),
        .s1_pos    (s1_pos),
        .s1_mptr   (s1_mptr),
        .s1_flags  (s1_flags)
    );

    cpag_addr #(
        .ADDR_BITS (ADDR_BITS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_pos      (s1_pos),
        .s1_mptr     (s1_mptr),
        .s1_flags    (s1_flags),
        .stride      (stride),
        .base        (vol_base_reg[ADDR_BITS-1:0]),
        .scatter     (scatter_mode_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vol_address (vol_address),
        .mat_address (mat_address),
        .action      (action),
        .last        (last)
    );

`ifndef NO_ASSERTIONS
    // An idle result word is the fixed inactive pattern.
    a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == ACT_NONE) |-> (last && vol_address == '0 && mat_address == '0))
        else $error("inactive result word carries addresses or no last flag");

    // Padding elements never carry a volume address.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_ZERO || action == ACT_SKIP)) |-> (vol_address == '0))
        else $error("padding element has a nonzero volume address");

    // With the output register empty, every stage can move, so the input is open.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output register is empty");
`endif

endmodule

// ===== hdl/cpag_scan.sv =====
// Patch scan counters and the first pipeline stage: element position and flags.
module cpag_scan #(
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    input  logic signed [cpag_pkg::OFF_W-1:0]      offset_d0,
    input  logic signed [cpag_pkg::OFF_W-1:0]      offset_d1,
    input  logic signed [cpag_pkg::OFF_W-1:0]      offset_d2,
    input  logic signed [cpag_pkg::OFF_W-1:0]      offset_d3,
    input  logic [cpag_pkg::OUT_W-1:0]             row,
    input  logic [3:0][DIM_BITS-1:0]               patch_ext,
    input  logic [3:0][DIM_BITS-1:0]               vol_ext,
    input  logic [ADDR_BITS-1:0]                   mat_step,
    input  logic                                   s1_ready,
    output logic                                   s1_valid,
    output logic [3:0][cpag_pkg::POS_W-1:0]        s1_pos,
    output logic [ADDR_BITS-1:0]                   s1_mptr,
    output cpag_pkg::elem_flags_t                  s1_flags
);
    import cpag_pkg::*;

    logic [3:0][DIM_BITS-1:0]  cnt_reg, cnt_next;
    logic [3:0][OFF_W-1:0]     off_reg, off_next;
    logic [ADDR_BITS-1:0]      mptr_reg, mptr_next;
    logic                      active_reg, active_next;

    logic                      s1_valid_reg, s1_valid_next;
    logic [3:0][POS_W-1:0]     s1_pos_reg, s1_pos_next;
    logic [ADDR_BITS-1:0]      s1_mptr_reg, s1_mptr_next;
    elem_flags_t               s1_flags_reg, s1_flags_next;

    logic [3:0][OFF_W-1:0]     off_in;
    logic [3:0][DIM_BITS-1:0]  cnt_cur;
    logic [3:0][DIM_BITS-1:0]  cnt_adv;
    logic [3:0][DIM_BITS:0]    cnt_inc;
    logic [4:0]                carry;
    logic [ADDR_BITS-1:0]      mptr_cur;
    logic                      active_cur;
    logic                      in_range;
    logic                      final_elem;
    logic                      stage_en;
    logic                      accept;

    assign stage_en = !s1_valid_reg || s1_ready;
    assign in_stall = !stage_en;
    assign accept   = in_valid && stage_en;

    assign off_in[0] = offset_d0;
    assign off_in[1] = offset_d1;
    assign off_in[2] = offset_d2;
    assign off_in[3] = offset_d3;

    always_comb
    begin
        off_next   = restart ? off_in : off_reg;
        cnt_cur    = restart ? '0 : cnt_reg;
        mptr_cur   = restart ? row[ADDR_BITS-1:0] : mptr_reg;
        active_cur = active_reg;
        if (restart)
        begin
            active_cur = 1'b1;
            for (int d = 0; d < DIMS; d++)
            begin
                if (patch_ext[d] == '0)
                begin
                    active_cur = 1'b0;
                end
            end
        end

        in_range   = 1'b1;
        final_elem = 1'b1;
        carry[0]   = 1'b1;
        for (int d = 0; d < DIMS; d++)
        begin
            s1_pos_next[d] = POS_W'(signed'(off_next[d])) + POS_W'(cnt_cur[d]);
            if (s1_pos_next[d][POS_W-1] || (s1_pos_next[d] >= POS_W'(vol_ext[d])))
            begin
                in_range = 1'b0;
            end
            cnt_inc[d] = (DIM_BITS+1)'(cnt_cur[d]) + (DIM_BITS+1)'(1);
            if (cnt_inc[d] != (DIM_BITS+1)'(patch_ext[d]))
            begin
                final_elem = 1'b0;
            end
            // Dimension 0 advances; a dimension that reaches its extent wraps
            // and passes the step on to the next one.
            if (!carry[d])
            begin
                cnt_adv[d]   = cnt_cur[d];
                carry[d+1]   = 1'b0;
            end
            else if (cnt_inc[d] < (DIM_BITS+1)'(patch_ext[d]))
            begin
                cnt_adv[d]   = cnt_inc[d][DIM_BITS-1:0];
                carry[d+1]   = 1'b0;
            end
            else
            begin
                cnt_adv[d]   = '0;
                carry[d+1]   = 1'b1;
            end
        end

        if (active_cur)
        begin
            cnt_next    = final_elem ? '0 : cnt_adv;
            mptr_next   = mptr_cur + mat_step;
            active_next = !final_elem;
        end
        else
        begin
            cnt_next    = cnt_cur;
            mptr_next   = mptr_cur;
            active_next = 1'b0;
        end

        s1_valid_next           = stage_en ? in_valid : s1_valid_reg;
        s1_mptr_next            = mptr_cur;
        s1_flags_next.active    = active_cur;
        s1_flags_next.in_range  = in_range;
        s1_flags_next.last      = final_elem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            off_reg      <= '0;
            mptr_reg     <= '0;
            active_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                cnt_reg    <= cnt_next;
                off_reg    <= off_next;
                mptr_reg   <= mptr_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= s1_pos_next;
            s1_mptr_reg  <= s1_mptr_next;
            s1_flags_reg <= s1_flags_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pos   = s1_pos_reg;
    assign s1_mptr  = s1_mptr_reg;
    assign s1_flags = s1_flags_reg;

endmodule

// ===== hdl/cpag_addr.sv =====
// Address stages: stride products, then the address sum and the output word.
module cpag_addr #(
    parameter int ADDR_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s1_valid,
    output logic                               s1_ready,
    input  logic [3:0][cpag_pkg::POS_W-1:0]    s1_pos,
    input  logic [ADDR_BITS-1:0]               s1_mptr,
    input  cpag_pkg::elem_flags_t              s1_flags,
    input  logic [3:0][ADDR_BITS-1:0]          stride,
    input  logic [ADDR_BITS-1:0]               base,
    input  logic                               scatter,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cpag_pkg::OUT_W-1:0]         vol_address,
    output logic [cpag_pkg::OUT_W-1:0]         mat_address,
    output logic [cpag_pkg::ACT_W-1:0]         action,
    output logic                               last
);
    import cpag_pkg::*;

    logic                          s2_valid_reg, s2_valid_next;
    logic [3:0][ADDR_BITS-1:0]     prod_reg, prod_next;
    logic [ADDR_BITS-1:0]          s2_mptr_reg;
    elem_flags_t                   s2_flags_reg;
    logic [3:0][ADDR_BITS-1:0]     pos_ext;

    logic                          out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]              vol_reg, vol_next;
    logic [OUT_W-1:0]              mat_reg, mat_next;
    logic [ACT_W-1:0]              action_reg, action_next;
    logic                          last_reg, last_next;
    logic [ADDR_BITS-1:0]          addr_sum;

    logic                          s2_en;
    logic                          s3_en;
    logic                          s2_load;
    logic                          s3_load;

    assign s3_en    = !out_valid_reg || !out_stall;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_ready = s2_en;
    assign s2_load  = s2_en && s1_valid;
    assign s3_load  = s3_en && s2_valid_reg;

    always_comb
    begin
        // Products are taken modulo the address width, so a negative
        // position works as its two's complement.
        for (int d = 0; d < DIMS; d++)
        begin
            pos_ext[d]   = ADDR_BITS'(signed'(s1_pos[d]));
            prod_next[d] = pos_ext[d] * stride[d];
        end
        s2_valid_next = s2_en ? s1_valid : s2_valid_reg;

        addr_sum = base + prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3];

        if (!s2_flags_reg.active)
        begin
            vol_next    = '0;
            mat_next    = '0;
            action_next = ACT_NONE;
            last_next   = 1'b1;
        end
        else
        begin
            vol_next  = s2_flags_reg.in_range ? OUT_W'(addr_sum) : '0;
            mat_next  = OUT_W'(s2_mptr_reg);
            last_next = s2_flags_reg.last;
            if (scatter)
            begin
                action_next = s2_flags_reg.in_range ? ACT_ADD : ACT_SKIP;
            end
            else
            begin
                action_next = s2_flags_reg.in_range ? ACT_COPY : ACT_ZERO;
            end
        end
        out_valid_next = s3_en ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            prod_reg     <= prod_next;
            s2_mptr_reg  <= s1_mptr;
            s2_flags_reg <= s1_flags;
        end
        if (s3_load)
        begin
            vol_reg    <= vol_next;
            mat_reg    <= mat_next;
            action_reg <= action_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vol_address = vol_reg;
    assign mat_address = mat_reg;
    assign action      = action_reg;
    assign last        = last_reg;

endmodule
